// ===== sv/printable_ascii_vigenere_cipher_macros.svh =====
// ----------------------------------------------------------------------------
// Vigenere cipher assertion macros
// Implication checks clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef PRINTABLE_ASCII_VIGENERE_CIPHER_MACROS_SVH
`define PRINTABLE_ASCII_VIGENERE_CIPHER_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define PAVC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pavc assertion failed");
// Next-cycle implication.
`define PAVC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pavc assertion failed");
`else
`define PAVC_ASSERT_NOW(lbl, ante, cons)
`define PAVC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== sv/pavc_pkg.sv =====
// ----------------------------------------------------------------------------
// Vigenere cipher package
// Shared constants, action codes and the request type between stages.
// ----------------------------------------------------------------------------
`default_nettype none

package pavc_pkg;

  localparam int KEY_DEPTH = 256;
  localparam int KEY_AW    = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
  localparam int KEY_LW    = $clog2(KEY_DEPTH + 1);

  localparam logic [7:0] CH_LOW   = 8'd32;
  localparam logic [7:0] CH_HIGH  = 8'd126;
  localparam logic [8:0] CH_MOD   = 9'd95;
  localparam logic [7:0] ESC_BYTE = 8'h1B;
  localparam logic [7:0] ESC_END  = 8'h6D;

  typedef enum logic [1:0] {
    ACT_START = 2'd0,
    ACT_KEY   = 2'd1,
    ACT_TEXT  = 2'd2
  } action_t;

  // One accepted text byte on its way to the output stage.
  typedef struct packed {
    logic       valid;
    logic       pass;
    logic       encrypt;
    logic [7:0] data_byte;
  } req_t;

  function automatic logic is_printable(input logic [7:0] b);
    return (b >= CH_LOW) && (b <= CH_HIGH);
  endfunction

endpackage

`default_nettype wire

// ===== sv/pavc_ifs.sv =====
// ----------------------------------------------------------------------------
// Vigenere cipher channels
// Valid/ready channels for input requests and output bytes.
// ----------------------------------------------------------------------------
`default_nettype none

interface pavc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] data_byte;
  logic       first_of_message;

  modport source (output valid, action, data_byte, first_of_message, input ready);
  modport sink   (input valid, action, data_byte, first_of_message, output ready);
endinterface

interface pavc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;

  modport source (output valid, out_byte, input ready);
  modport sink   (input valid, out_byte, output ready);
endinterface

`default_nettype wire

// ===== sv/pavc_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered, enable-held read.
// ----------------------------------------------------------------------------
`default_nettype none

module pavc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== sv/pavc_ctrl.sv =====
// ----------------------------------------------------------------------------
// Vigenere cipher key control
// Holds key length, key position, escape state and mode; drives the key RAM.
// ----------------------------------------------------------------------------
`default_nettype none

`include "printable_ascii_vigenere_cipher_macros.svh"

module pavc_ctrl (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_fire,
  input  wire logic [1:0]                 action,
  input  wire logic [7:0]                 data_byte,
  input  wire logic                       first_of_message,
  input  wire logic                       cfg_wr_en,
  input  wire logic                       cfg_wr_data,
  output logic                            key_wr_en,
  output logic [pavc_pkg::KEY_AW-1:0]     key_wr_addr,
  output logic [6:0]                      key_wr_data,
  output logic                            key_rd_en,
  output logic [pavc_pkg::KEY_AW-1:0]     key_rd_addr,
  output pavc_pkg::req_t                  req
);

  localparam int AW = pavc_pkg::KEY_AW;
  localparam int LW = pavc_pkg::KEY_LW;

  logic [LW-1:0] key_len_r, key_len_nxt;
  logic [AW-1:0] pos_r, pos_nxt;
  logic          esc_r, esc_nxt;
  logic          mode_r;

  logic [AW-1:0] pos_eff;
  logic [LW-1:0] pos_inc;
  logic          printable;
  logic          key_full;

  assign printable = pavc_pkg::is_printable(data_byte);
  assign key_full  = (key_len_r >= LW'(pavc_pkg::KEY_DEPTH));

  always_comb begin
    pos_eff = first_of_message ? '0 : pos_r;
    if (LW'(pos_eff) >= key_len_r) begin
      pos_eff = '0;
    end
    pos_inc = LW'(pos_eff) + LW'(1);
  end

  always_comb begin
    key_len_nxt   = key_len_r;
    pos_nxt       = pos_r;
    esc_nxt       = esc_r;
    key_wr_en     = 1'b0;
    key_rd_en     = 1'b0;
    req.valid     = 1'b0;
    req.pass      = 1'b0;
    req.encrypt   = mode_r;
    req.data_byte = data_byte;
    if (in_fire) begin
      unique case (action)
        pavc_pkg::ACT_START: begin
          key_len_nxt = '0;
          pos_nxt     = '0;
          esc_nxt     = 1'b0;
        end
        pavc_pkg::ACT_KEY: begin
          if (esc_r) begin
            if (data_byte == pavc_pkg::ESC_END) begin
              esc_nxt = 1'b0;
            end
          end else if (data_byte == pavc_pkg::ESC_BYTE) begin
            esc_nxt = 1'b1;
          end else if (printable && !key_full) begin
            key_wr_en   = 1'b1;
            key_len_nxt = key_len_r + LW'(1);
          end
        end
        pavc_pkg::ACT_TEXT: begin
          pos_nxt = pos_eff;
          if (key_len_r == '0) begin
            req.valid = 1'b1;
            req.pass  = 1'b1;
          end else if (printable) begin
            req.valid = 1'b1;
            key_rd_en = 1'b1;
            pos_nxt   = (pos_inc >= key_len_r) ? '0 : pos_inc[AW-1:0];
          end
        end
        default: begin
        end
      endcase
    end
  end

  // A key write and a text read never share a cycle, so the RAM needs no bypass.
  assign key_wr_addr = key_len_r[AW-1:0];
  assign key_wr_data = data_byte[6:0];
  assign key_rd_addr = pos_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_len_r <= '0;
      pos_r     <= '0;
      esc_r     <= 1'b0;
      mode_r    <= 1'b1;
    end else begin
      key_len_r <= key_len_nxt;
      pos_r     <= pos_nxt;
      esc_r     <= esc_nxt;
      if (cfg_wr_en) begin
        mode_r <= cfg_wr_data;
      end
    end
  end

  `PAVC_ASSERT_NOW(a_pos_below_len, key_len_r != '0, LW'(pos_r) < key_len_r)
  `PAVC_ASSERT_NOW(a_len_bounded, 1'b1, key_len_r <= LW'(pavc_pkg::KEY_DEPTH))
  `PAVC_ASSERT_NOW(a_rw_exclusive, key_wr_en, !key_rd_en && !req.valid)

endmodule

`default_nettype wire

// ===== sv/pavc_out.sv =====
// ----------------------------------------------------------------------------
// Vigenere cipher result stage
// Combines the key RAM read with the text byte and holds the output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "printable_ascii_vigenere_cipher_macros.svh"

module pavc_out (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  pavc_pkg::req_t      req,
  input  wire logic [6:0]     key_char,
  output logic                take,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic [7:0]          out_byte
);

  logic       s1_valid_r;
  logic       s1_pass_r;
  logic       s1_enc_r;
  logic [7:0] s1_byte_r;
  logic       out_valid_r;
  logic [7:0] out_byte_r;

  logic       advance;
  logic [8:0] sum;
  logic [8:0] red;
  logic [7:0] res;

  assign advance = !out_valid_r || out_ready;
  assign take    = !s1_valid_r || advance;

  // Both forms stay in 0..189, so one conditional subtract reduces mod 95.
  always_comb begin
    if (s1_enc_r) begin
      sum = {1'b0, s1_byte_r} + {2'b00, key_char} - 9'd64;
    end else begin
      sum = {1'b0, s1_byte_r} - {2'b00, key_char} + pavc_pkg::CH_MOD;
    end
    red = (sum >= pavc_pkg::CH_MOD) ? (sum - pavc_pkg::CH_MOD) : sum;
    res = red[7:0] + pavc_pkg::CH_LOW;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (take) begin
        s1_valid_r <= req.valid;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && req.valid) begin
      s1_pass_r <= req.pass;
      s1_enc_r  <= req.encrypt;
      s1_byte_r <= req.data_byte;
    end
    if (advance && s1_valid_r) begin
      out_byte_r <= s1_pass_r ? s1_byte_r : res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;

  `PAVC_ASSERT_NOW(a_no_overrun, s1_valid_r && !advance, !take)
  `PAVC_ASSERT_NEXT(a_stall_holds_s1, s1_valid_r && !advance, s1_valid_r)

endmodule

`default_nettype wire

// ===== sv/printable_ascii_vigenere_cipher.sv =====
// ----------------------------------------------------------------------------
// Printable ASCII Vigenere cipher
// Mod-95 key cipher over characters 32..126 with a key RAM and escape filter.
//
//   Channel   Dir   Contents
//   in_chan   in    action, data_byte, first_of_message
//   out_chan  out   out_byte
//   cfg_*     in    encrypt_mode write
//
// One request is taken every cycle while the output side keeps up.
// A text byte reads the key RAM in its accept cycle; the byte is registered in the
// result stage and its result then enters the output register once that is free.
// Reset is synchronous; it empties the key and sets encrypt mode. The key RAM
// is not cleared, since only entries written since the last new key are read.
// A stalled output holds the result stage, and input ready drops after that.
// ----------------------------------------------------------------------------
`default_nettype none

module printable_ascii_vigenere_cipher (
  input  wire logic   clk,
  input  wire logic   rst_n,
  pavc_in_if.sink     in_chan,
  pavc_out_if.source  out_chan,
  input  wire logic   cfg_wr_en,
  input  wire logic   cfg_wr_data
);

  localparam int AW = pavc_pkg::KEY_AW;

  logic           take;
  logic           in_fire;
  logic           key_wr_en;
  logic [AW-1:0]  key_wr_addr;
  logic [6:0]     key_wr_data;
  logic           key_rd_en;
  logic [AW-1:0]  key_rd_addr;
  logic [6:0]     key_char;
  pavc_pkg::req_t req;

  assign in_chan.ready = take;
  assign in_fire       = in_chan.valid && take;

  pavc_ctrl u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_fire          (in_fire),
    .action           (in_chan.action),
    .data_byte        (in_chan.data_byte),
    .first_of_message (in_chan.first_of_message),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .key_wr_en        (key_wr_en),
    .key_wr_addr      (key_wr_addr),
    .key_wr_data      (key_wr_data),
    .key_rd_en        (key_rd_en),
    .key_rd_addr      (key_rd_addr),
    .req              (req)
  );

  pavc_ram #(
    .WIDTH (7),
    .DEPTH (pavc_pkg::KEY_DEPTH),
    .AW    (AW)
  ) u_key_ram (
    .clk     (clk),
    .wr_en   (key_wr_en),
    .wr_addr (key_wr_addr),
    .wr_data (key_wr_data),
    .rd_en   (key_rd_en),
    .rd_addr (key_rd_addr),
    .rd_data (key_char)
  );

  pavc_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (req),
    .key_char  (key_char),
    .take      (take),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_byte  (out_chan.out_byte)
  );

endmodule

`default_nettype wire

// ===== bench/printable_ascii_vigenere_cipher_tb.sv =====
// ----------------------------------------------------------------------------
// Vigenere cipher testbench
// Drives key loads and text messages through the cipher in both directions and
// checks every output byte against a mod-95 cipher model kept in the bench.
// Sender bursts are random; the receiver may stall at random or on a pattern.
// ----------------------------------------------------------------------------
`default_nettype none

module printable_ascii_vigenere_cipher_tb;

  localparam logic [1:0] ACT_UNUSED = 2'd3;

  localparam int ITEM_TARGET     = 1550;
  localparam int PHASE_ITEMS     = 250;
  localparam int SETTLE_CYCLES   = 6;
  localparam int HOLD_CYCLES     = 300;
  localparam int DRAIN_LIMIT     = 20000;
  localparam int WATCHDOG_CYCLES = 400000;
  localparam int REPORT_LIMIT    = 10;

  typedef enum {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_style_t;

  // Bench copy of the cipher state; expected bytes wait in arrival order.
  class cipher_checker;
    bit [6:0]     key_chars [pavc_pkg::KEY_DEPTH];
    int unsigned  key_len;
    int unsigned  key_pos;
    bit           in_escape;
    bit           encrypt;
    logic [7:0]   pending_bytes [$];
    int unsigned  errors;
    int unsigned  reported;
    int unsigned  checked;
    int unsigned  text_reqs;
    int unsigned  key_loads;
    int unsigned  longest_key;

    function new();
      key_len   = 0;
      key_pos   = 0;
      in_escape = 1'b0;
      encrypt   = 1'b1;
      errors    = 0;
      reported  = 0;
      checked   = 0;
      text_reqs = 0;
      key_loads = 0;
      longest_key = 0;
    endfunction

    function bit char_ok(logic [7:0] b);
      return b >= pavc_pkg::CH_LOW && b <= pavc_pkg::CH_HIGH;
    endfunction

    function int unsigned pending();
      return pending_bytes.size();
    endfunction

    function void flag(string what);
      errors++;
      if (reported < REPORT_LIMIT) begin
        reported++;
        $display("ERROR: %s", what);
      end
    endfunction

    function void note_request(logic [1:0] act, logic [7:0] b, logic first);
      int unsigned t;
      int unsigned k;
      int unsigned r;
      case (act)
        pavc_pkg::ACT_START: begin
          key_len   = 0;
          key_pos   = 0;
          in_escape = 1'b0;
          key_loads++;
        end
        pavc_pkg::ACT_KEY: begin
          if (in_escape) begin
            if (b == pavc_pkg::ESC_END) in_escape = 1'b0;
          end else if (b == pavc_pkg::ESC_BYTE) begin
            in_escape = 1'b1;
          end else if (char_ok(b) && key_len < pavc_pkg::KEY_DEPTH) begin
            key_chars[key_len] = b[6:0];
            key_len++;
            if (key_len > longest_key) longest_key = key_len;
          end
        end
        pavc_pkg::ACT_TEXT: begin
          text_reqs++;
          if (first) key_pos = 0;
          if (key_len == 0) begin
            pending_bytes.push_back(b);
          end else if (char_ok(b)) begin
            if (key_pos >= key_len) key_pos = 0;
            t = 32'(b);
            k = 32'(key_chars[key_pos]);
            if (encrypt)
              r = ((t - pavc_pkg::CH_LOW) + (k - pavc_pkg::CH_LOW)) % pavc_pkg::CH_MOD
                  + pavc_pkg::CH_LOW;
            else
              r = (t + 2 * pavc_pkg::CH_MOD - k) % pavc_pkg::CH_MOD + pavc_pkg::CH_LOW;
            key_pos++;
            if (key_pos >= key_len) key_pos = 0;
            pending_bytes.push_back(r[7:0]);
          end
        end
        default: ;
      endcase
    endfunction

    function void check_byte(logic [7:0] got);
      logic [7:0] want;
      if (pending_bytes.size() == 0) begin
        flag($sformatf("output byte 0x%02h with nothing expected", got));
        return;
      end
      want = pending_bytes.pop_front();
      checked++;
      if (got !== want)
        flag($sformatf("out_byte expected 0x%02h, got 0x%02h", want, got));
    endfunction

    function void close_out();
      if (pending_bytes.size() != 0) begin
        errors += pending_bytes.size();
        $display("ERROR: %0d expected output bytes never arrived", pending_bytes.size());
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic cfg_wr_data;

  pavc_in_if  in_chan ();
  pavc_out_if out_chan ();

  printable_ascii_vigenere_cipher dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_chan),
    .out_chan    (out_chan),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  cipher_checker cipher_chk;
  rx_style_t     rx_style;
  bit            tx_gaps;
  int unsigned   burst_left;
  int unsigned   sent_items;
  int unsigned   holds_done;
  bit            hold_request;

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    repeat (WATCHDOG_CYCLES) @(posedge clk);
    $display("DONE: errors detected");
    $finish;
  end

  // Receiver: ready changes at the falling edge; a hold request parks it low.
  initial begin : receiver
    logic [7:0] stall_mask;
    stall_mask     = 8'b1101_1010;
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request   = 1'b0;
        out_chan.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        holds_done++;
      end
      stall_mask = {stall_mask[0], stall_mask[7:1]};
      case (rx_style)
        RX_ALWAYS: out_chan.ready = 1'b1;
        RX_RANDOM: out_chan.ready = ($urandom_range(9) < 6);
        default:   out_chan.ready = stall_mask[0];
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_chan.valid === 1'b1 && out_chan.ready === 1'b1)
      cipher_chk.check_byte(out_chan.out_byte);
  end

  function automatic logic [7:0] rand_byte();
    logic [7:0] v;
    v = 8'($urandom_range(255));
    return v;
  endfunction

  function automatic logic [7:0] rand_char();
    logic [7:0] v;
    v = 8'($urandom_range(pavc_pkg::CH_HIGH, pavc_pkg::CH_LOW));
    return v;
  endfunction

  function automatic logic coin();
    return $urandom_range(1) == 1;
  endfunction

  // Offers one request and returns at the edge where it is taken. Valid stays
  // high afterwards so back-to-back requests need no extra edge.
  task automatic offer(input logic [1:0] act, input logic [7:0] b, input logic first);
    if (tx_gaps) begin
      if (burst_left == 0) begin
        @(negedge clk);
        in_chan.valid = 1'b0;
        repeat ($urandom_range(6, 1)) @(posedge clk);
        burst_left = $urandom_range(16, 1);
      end
      burst_left--;
    end
    @(negedge clk);
    in_chan.valid            = 1'b1;
    in_chan.action           = act;
    in_chan.data_byte        = b;
    in_chan.first_of_message = first;
    do @(posedge clk); while (in_chan.ready !== 1'b1);
    cipher_chk.note_request(act, b, first);
    if (act != ACT_UNUSED) sent_items++;
  endtask

  task automatic quiet_input();
    @(negedge clk);
    in_chan.valid = 1'b0;
  endtask

  task automatic write_mode(input logic enc);
    quiet_input();
    while (cipher_chk.pending() != 0) @(posedge clk);
    // Dropped bytes leave no result behind, so give the pipeline time to empty.
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = enc;
    @(posedge clk);
    cipher_chk.encrypt = enc;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  task automatic run_directed();
    // Empty key: everything passes through, printable or not.
    offer(pavc_pkg::ACT_TEXT, 8'h00, 1'b1);
    offer(pavc_pkg::ACT_TEXT, 8'hFF, 1'b0);
    offer(pavc_pkg::ACT_TEXT, "A", 1'b0);
    offer(ACT_UNUSED, 8'h55, 1'b1);
    // Key " ~K": the escape run and the non-printable bytes are all dropped.
    offer(pavc_pkg::ACT_START, 8'hAA, 1'b0);
    offer(pavc_pkg::ACT_KEY, pavc_pkg::CH_LOW, 1'b0);
    offer(pavc_pkg::ACT_KEY, pavc_pkg::CH_HIGH, 1'b1);
    offer(pavc_pkg::ACT_KEY, pavc_pkg::ESC_BYTE, 1'b0);
    offer(pavc_pkg::ACT_KEY, "Q", 1'b0);
    offer(pavc_pkg::ACT_KEY, pavc_pkg::ESC_BYTE, 1'b0);
    offer(pavc_pkg::ACT_KEY, pavc_pkg::ESC_END, 1'b0);
    offer(pavc_pkg::ACT_KEY, 8'h1F, 1'b0);
    offer(pavc_pkg::ACT_KEY, 8'h7F, 1'b0);
    offer(pavc_pkg::ACT_KEY, 8'h80, 1'b0);
    offer(pavc_pkg::ACT_KEY, "K", 1'b0);
    offer(pavc_pkg::ACT_TEXT, pavc_pkg::CH_LOW, 1'b1);
    offer(pavc_pkg::ACT_TEXT, pavc_pkg::CH_HIGH, 1'b0);
    offer(pavc_pkg::ACT_TEXT, 8'h7F, 1'b0);
    offer(pavc_pkg::ACT_TEXT, "z", 1'b0);
    offer(pavc_pkg::ACT_TEXT, "H", 1'b1);
    offer(pavc_pkg::ACT_TEXT, 8'h00, 1'b1);
    offer(pavc_pkg::ACT_TEXT, pavc_pkg::CH_HIGH, 1'b0);
    // An escape left open just ends the key.
    offer(pavc_pkg::ACT_START, 8'h00, 1'b1);
    offer(pavc_pkg::ACT_KEY, "a", 1'b0);
    offer(pavc_pkg::ACT_KEY, pavc_pkg::ESC_BYTE, 1'b0);
    offer(pavc_pkg::ACT_KEY, "b", 1'b0);
    offer(pavc_pkg::ACT_TEXT, pavc_pkg::CH_HIGH, 1'b1);
  endtask

  task automatic key_unit();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 80) begin
      offer(pavc_pkg::ACT_KEY, rand_char(), coin());
    end else if (r < 88) begin
      offer(pavc_pkg::ACT_KEY, rand_byte(), coin());
    end else begin
      offer(pavc_pkg::ACT_KEY, pavc_pkg::ESC_BYTE, coin());
      repeat ($urandom_range(3)) offer(pavc_pkg::ACT_KEY, rand_byte(), coin());
      offer(pavc_pkg::ACT_KEY, pavc_pkg::ESC_END, coin());
    end
  endtask

  task automatic cipher_session();
    int unsigned nkey;
    int unsigned msgs;
    int unsigned len;
    int unsigned r;
    logic        first;
    if ($urandom_range(9) != 0) offer(pavc_pkg::ACT_START, rand_byte(), coin());
    nkey = ($urandom_range(11) == 0) ? 0 : $urandom_range(12, 1);
    repeat (nkey) key_unit();
    if ($urandom_range(9) == 0) begin
      offer(pavc_pkg::ACT_KEY, pavc_pkg::ESC_BYTE, coin());
      repeat ($urandom_range(3)) offer(pavc_pkg::ACT_KEY, rand_char(), coin());
    end
    msgs = $urandom_range(4, 1);
    repeat (msgs) begin
      len = $urandom_range(24, 1);
      for (int j = 0; j < len; j++) begin
        r     = $urandom_range(99);
        first = (j == 0) || ($urandom_range(32) == 0);
        if (r < 3) offer(ACT_UNUSED, rand_byte(), coin());
        else if (r < 6) offer(pavc_pkg::ACT_KEY, rand_char(), coin());
        else if (r < 14) offer(pavc_pkg::ACT_TEXT, rand_byte(), first);
        else offer(pavc_pkg::ACT_TEXT, rand_char(), first);
      end
    end
  endtask

  // Overfills the key store, then runs a message long enough to wrap the key.
  task automatic full_key_session();
    int unsigned stored;
    offer(pavc_pkg::ACT_START, rand_byte(), 1'b0);
    stored = 0;
    while (stored < pavc_pkg::KEY_DEPTH + 8) begin
      if ($urandom_range(19) == 0) begin
        offer(pavc_pkg::ACT_KEY, 8'($urandom_range(31)), coin());
      end else begin
        offer(pavc_pkg::ACT_KEY, rand_char(), coin());
        stored++;
      end
    end
    for (int j = 0; j < pavc_pkg::KEY_DEPTH + 40; j++)
      offer(pavc_pkg::ACT_TEXT, rand_char(), j == 0);
  endtask

  initial begin : stimulus
    int unsigned phase;
    int unsigned phase_end;
    int unsigned waited;
    cipher_chk   = new();
    rx_style     = RX_ALWAYS;
    tx_gaps      = 1'b0;
    burst_left   = 0;
    sent_items   = 0;
    holds_done   = 0;
    hold_request = 1'b0;
    rst_n        = 1'b0;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = 1'b0;
    in_chan.valid            = 1'b0;
    in_chan.action           = pavc_pkg::ACT_START;
    in_chan.data_byte        = 8'h00;
    in_chan.first_of_message = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    write_mode(1'b1);
    run_directed();

    phase = 0;
    while (sent_items < ITEM_TARGET) begin
      write_mode(phase[0]);
      case (phase % 3)
        0: begin
          tx_gaps  = 1'b0;
          rx_style = RX_ALWAYS;
        end
        1: begin
          tx_gaps  = 1'b1;
          rx_style = RX_RANDOM;
        end
        default: begin
          tx_gaps  = 1'b1;
          rx_style = RX_PATTERN;
        end
      endcase
      if (phase == 1) full_key_session();
      if (phase % 3 == 2) begin
        // Keep offering while the receiver is parked so the input backs up.
        tx_gaps      = 1'b0;
        hold_request = 1'b1;
      end
      phase_end = sent_items + PHASE_ITEMS;
      while (sent_items < phase_end && sent_items < ITEM_TARGET) cipher_session();
      phase++;
    end

    quiet_input();
    waited = 0;
    while (cipher_chk.pending() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    cipher_chk.close_out();
    $display("Covered %0d requests (%0d text) over %0d key loads in both directions.",
             sent_items, cipher_chk.text_reqs, cipher_chk.key_loads);
    $display("Checked %0d output bytes; longest key %0d, receiver holds %0d.",
             cipher_chk.checked, cipher_chk.longest_key, holds_done);
    if (cipher_chk.errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

`default_nettype wire
